// File: hdl/pscan_pkg.sv
package pscan_pkg;

  // Input beat: one character, or the end-of-text marker
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_item_t;

  // Output beat: one scan result
  typedef struct packed {
    logic       token_valid;
    logic [5:0] token_kind;
    logic [7:0] ident_length;
    logic       lex_error;
    logic       text_done;
  } tok_item_t;

  // Classified entry held in the queue between front and back
  typedef struct packed {
    logic       end_flag;
    logic [4:0] char_class;
  } q_item_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [4:0] CLASS_LETTER = 5'd0;
  localparam logic [4:0] CLASS_DIGIT  = 5'd1;
  localparam logic [4:0] CLASS_NONE   = 5'd25;

  localparam logic [5:0] NO_STATE         = 6'd0;
  localparam logic [5:0] START_STATE      = 6'd1;
  localparam logic [5:0] IDENT_STATE      = 6'd2;
  localparam logic [5:0] LAST_PLAIN_STATE = 6'd39;
  localparam logic [5:0] UNDERSCORE_STATE = 6'd40;
  localparam logic [5:0] TAB_STATE        = 6'd41;

  localparam logic [5:0] KIND_NONE  = 6'd0;
  localparam logic [5:0] KIND_IDENT = 6'd2;
  localparam logic [5:0] KIND_BLANK = 6'd24;

  function automatic logic [4:0] classify(input logic [7:0] c);
    logic [4:0] cls;
    cls = CLASS_NONE;
    case (c)
      8'h3D: cls = 5'd2;   // =
      8'h3C: cls = 5'd3;   // <
      8'h3E: cls = 5'd4;   // >
      8'h2B: cls = 5'd5;   // +
      8'h2D: cls = 5'd6;   // -
      8'h2A: cls = 5'd7;   // *
      8'h2E: cls = 5'd8;   // .
      8'h3A: cls = 5'd9;   // :
      8'h28: cls = 5'd10;  // (
      8'h29: cls = 5'd11;  // )
      8'h5B: cls = 5'd12;  // [
      8'h5D: cls = 5'd13;  // ]
      8'h2C: cls = 5'd14;  // ,
      8'h0A: cls = 5'd15;  // line feed
      8'h20: cls = 5'd16;  // space
      8'h3B: cls = 5'd17;  // ;
      8'h2F: cls = 5'd18;  // /
      8'h5E: cls = 5'd19;  // ^
      8'h40: cls = 5'd20;  // @
      8'h24: cls = 5'd21;  // $
      8'h23: cls = 5'd22;  // #
      8'h5F: cls = 5'd23;  // _
      8'h09: cls = 5'd24;  // tab
      default: begin
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
          cls = CLASS_LETTER;
        end else if (c >= 8'h30 && c <= 8'h39) begin
          cls = CLASS_DIGIT;
        end
      end
    endcase
    return cls;
  endfunction

  // DFA transition table; NO_STATE where no transition exists
  function automatic logic [5:0] next_state(input logic [5:0] st, input logic [4:0] cls);
    logic [5:0] nxt;
    nxt = NO_STATE;
    case (st)
      6'd1: begin
        case (cls)
          5'd0:  nxt = 6'd2;
          5'd1:  nxt = 6'd3;
          5'd2:  nxt = 6'd4;
          5'd3:  nxt = 6'd5;
          5'd4:  nxt = 6'd8;
          5'd5:  nxt = 6'd10;
          5'd6:  nxt = 6'd11;
          5'd7:  nxt = 6'd12;
          5'd8:  nxt = 6'd13;
          5'd9:  nxt = 6'd15;
          5'd10: nxt = 6'd17;
          5'd11: nxt = 6'd19;
          5'd12: nxt = 6'd20;
          5'd13: nxt = 6'd21;
          5'd14: nxt = 6'd22;
          5'd15: nxt = 6'd23;
          5'd16: nxt = 6'd24;
          5'd17: nxt = 6'd25;
          5'd18: nxt = 6'd26;
          5'd19: nxt = 6'd27;
          5'd20: nxt = 6'd28;
          5'd21: nxt = 6'd29;
          5'd22: nxt = 6'd30;
          5'd23: nxt = 6'd40;
          5'd24: nxt = 6'd41;
          default: nxt = NO_STATE;
        endcase
      end
      6'd2:  if (cls == 5'd0) nxt = 6'd2;
      6'd5: begin
        if (cls == 5'd2) nxt = 6'd7;
        else if (cls == 5'd4) nxt = 6'd6;
      end
      6'd8:  if (cls == 5'd2) nxt = 6'd9;
      6'd10: if (cls == 5'd2) nxt = 6'd31;
      6'd11: if (cls == 5'd2) nxt = 6'd32;
      6'd12: begin
        if (cls == 5'd2) nxt = 6'd33;
        else if (cls == 5'd11) nxt = 6'd36;
      end
      6'd13: begin
        if (cls == 5'd8) nxt = 6'd14;
        else if (cls == 5'd11) nxt = 6'd38;
      end
      6'd15: if (cls == 5'd2) nxt = 6'd16;
      6'd17: begin
        if (cls == 5'd11) nxt = 6'd18;
        else if (cls == 5'd8) nxt = 6'd37;
        else if (cls == 5'd7) nxt = 6'd35;
      end
      6'd26: begin
        if (cls == 5'd18) nxt = 6'd39;
        else if (cls == 5'd2) nxt = 6'd34;
      end
      default: nxt = NO_STATE;
    endcase
    return nxt;
  endfunction

  // Token kind of the state last reached; start and dead states give none
  function automatic logic [5:0] kind_of(input logic [5:0] st);
    logic [5:0] k;
    k = KIND_NONE;
    if (st == IDENT_STATE || st == UNDERSCORE_STATE) begin
      k = KIND_IDENT;
    end else if (st == TAB_STATE) begin
      k = KIND_BLANK;
    end else if (st > IDENT_STATE && st <= LAST_PLAIN_STATE) begin
      k = st;
    end
    return k;
  endfunction

endpackage

// File: hdl/pscan_front.sv
module pscan_front
  import pscan_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  output logic       q_valid,
  output q_item_t    q_item,
  input  logic       q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  q_item_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  q_item_t          push_item;

  assign char_stall = (count == FULL_COUNT);
  assign push       = char_valid && !char_stall;
  assign q_valid    = (count != '0);
  assign q_item     = entries[rd_ptr];

  always_comb begin
    push_item.end_flag   = char_item.end_of_text;
    push_item.char_class = classify(char_item.char_code);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// File: hdl/pscan_back.sv
module pscan_back
  import pscan_pkg::*;
#(
  parameter int MAX_IDENT_LEN = 255
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  output logic      tok_valid,
  input  logic      tok_stall,
  output tok_item_t tok_item
);

  localparam logic [7:0] LEN_LIMIT = (MAX_IDENT_LEN < 255) ? 8'(MAX_IDENT_LEN) : 8'd255;

  logic [5:0] scan_state, scan_state_next;
  logic [7:0] word_length, word_length_next;
  logic       halted, halted_next;

  logic       load;
  logic       res_valid;
  tok_item_t  res;
  tok_item_t  flush_item;
  logic [5:0] pend_kind;
  logic [5:0] step_first;
  logic [5:0] step_final;
  logic       restart;
  logic [7:0] base_len;

  // accept state equals scan state once anything is taken, so kind comes from scan state
  assign pend_kind = kind_of(scan_state);
  assign load      = !tok_valid || !tok_stall;
  assign q_pop     = q_valid && load;

  always_comb begin
    flush_item              = '0;
    flush_item.token_valid  = (pend_kind != KIND_NONE);
    flush_item.token_kind   = pend_kind;
    flush_item.ident_length = (pend_kind == KIND_IDENT) ? word_length : 8'd0;

    step_first = next_state(scan_state, q_item.char_class);
    restart    = (step_first == NO_STATE);
    step_final = restart ? next_state(START_STATE, q_item.char_class) : step_first;
    base_len   = restart ? 8'd0 : word_length;

    res_valid        = 1'b0;
    res              = '0;
    scan_state_next  = scan_state;
    word_length_next = word_length;
    halted_next      = halted;

    if (q_pop && !halted) begin
      if (q_item.end_flag) begin
        res              = flush_item;
        res.text_done    = 1'b1;
        res_valid        = 1'b1;
        scan_state_next  = START_STATE;
        word_length_next = 8'd0;
      end else if (q_item.char_class == CLASS_NONE) begin
        if (scan_state != START_STATE) res = flush_item;
        res.lex_error    = 1'b1;
        res_valid        = 1'b1;
        halted_next      = 1'b1;
        scan_state_next  = START_STATE;
        word_length_next = 8'd0;
      end else begin
        scan_state_next = step_final;
        if (step_final == IDENT_STATE && base_len < LEN_LIMIT) begin
          word_length_next = base_len + 8'd1;
        end else begin
          word_length_next = base_len;
        end
        if (restart) begin
          res       = flush_item;
          res_valid = flush_item.token_valid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state  <= START_STATE;
      word_length <= 8'd0;
      halted      <= 1'b0;
      tok_valid   <= 1'b0;
    end else begin
      scan_state  <= scan_state_next;
      word_length <= word_length_next;
      halted      <= halted_next;
      if (load) tok_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) tok_item <= res;
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt released without reset");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_item.lex_error) |-> halted)
    else $error("error reported but block still running");

  a_len_ident_only: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_item.token_kind != KIND_IDENT) |-> (tok_item.ident_length == 8'd0))
    else $error("length on a non-identifier token");

endmodule

// File: hdl/pascal_token_scanner_dfa.sv
// Pascal token scanner, table-driven DFA.
// char channel: one beat per source character (char_code) or an end-of-text
//   marker; the beat is taken on a clock edge with char_valid high and
//   char_stall low.
// tok channel: one beat per result, same valid/stall rule. A beat carries a
//   finished token (kind, identifier length), an error flag, or the end-of-
//   text answer. Characters that only extend a token give no beat.
// Throughput: one character per cycle sustained while tok_stall is low. A
//   result reaches tok through the queue: the classifier writes a
//   four-entry queue at the accepting edge, and the DFA step registers the
//   result from the queue head.
// A tok_stall holds the output register; the queue keeps absorbing up to
//   four characters, then char_stall rises.
// An unknown character reports any pending token with lex_error set and
//   halts the scanner; later beats are taken and dropped until reset.
// Reset (rst, synchronous) empties the queue, clears tok_valid and puts the
//   scanner at the start state with nothing pending. No clearing pass.
module pascal_token_scanner_dfa
  import pscan_pkg::*;
#(
  parameter int MAX_IDENT_LEN = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  output logic       tok_valid,
  input  logic       tok_stall,
  output tok_item_t  tok_item
);

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  // front: classify and queue
  pscan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // back: DFA step, token emission, output register
  pscan_back #(
    .MAX_IDENT_LEN (MAX_IDENT_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
  );

endmodule
